### rtl/isa_pkg.sv
`default_nettype none

package isa_pkg;

  localparam int SLOT_COUNT   = 64;
  localparam int NUMBER_COUNT = 256;
  localparam int SLOT_W       = $clog2(SLOT_COUNT);
  localparam int NUM_W        = $clog2(NUMBER_COUNT);

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOMAP = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic              set;
    logic              clr;
    logic [SLOT_W-1:0] idx;
  } bitmap_ctl_t;

endpackage

`default_nettype wire

### rtl/isa_ram.sv
`default_nettype none

module isa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/isa_bitmap.sv
`default_nettype none

module isa_bitmap
  import isa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bitmap_ctl_t       ctl,
  output logic                   full,
  output logic      [SLOT_W-1:0] free_idx
);

  logic [SLOT_COUNT-1:0] used;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (ctl.set) begin
      used[ctl.idx] <= 1'b1;
    end else if (ctl.clr) begin
      used[ctl.idx] <= 1'b0;
    end
  end

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign full = &used;

endmodule

`default_nettype wire

### rtl/irq_slot_allocator.sv
`default_nettype none

// Each input transaction reads the number-to-slot table when accepted (S_IDLE),
// then updates it and registers the result (S_EXEC); in_stall holds off a new
// transaction until that update is done; a result held by out_stall delays the update cycle.
// Reset (rst, synchronous): all slots free and all numbers unmapped at once,
// no clearing pass; no result pending.
module irq_slot_allocator
  import isa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             func,
  input  wire logic [NUM_W-1:0] irq_number,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic     [SLOT_W-1:0] slot,
  output logic            [1:0] status
);

  state_t            state, state_next;
  logic              req_func;
  logic [NUM_W-1:0]  req_num;
  logic [NUMBER_COUNT-1:0] mapped;
  logic [SLOT_W-1:0] map_rdata;
  logic              rd_en;
  logic              exec_go;
  logic              accept;
  logic              full;
  logic [SLOT_W-1:0] free_idx;
  bitmap_ctl_t       bm_ctl;
  logic              map_we;
  logic [SLOT_W-1:0] res_slot;
  status_t           res_status;

  assign accept = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    exec_go  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        rd_en    = in_valid;
      end
      S_EXEC: exec_go = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_func <= func;
      req_num  <= irq_number;
    end
  end

  isa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (NUMBER_COUNT)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (req_num),
    .wdata (free_idx),
    .re    (rd_en),
    .raddr (irq_number),
    .rdata (map_rdata)
  );

  isa_bitmap u_bitmap (
    .clk      (clk),
    .rst      (rst),
    .ctl      (bm_ctl),
    .full     (full),
    .free_idx (free_idx)
  );

  always_comb begin
    bm_ctl     = '0;
    map_we     = 1'b0;
    res_slot   = '0;
    res_status = ST_DONE;
    if (!req_func) begin
      if (full) begin
        res_status = ST_FULL;
      end else begin
        res_slot   = free_idx;
        bm_ctl.idx = free_idx;
        bm_ctl.set = exec_go;
        map_we     = exec_go;
      end
    end else begin
      if (!mapped[req_num]) begin
        res_status = ST_NOMAP;
      end else begin
        res_slot   = map_rdata;
        bm_ctl.idx = map_rdata;
        bm_ctl.clr = exec_go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mapped <= '0;
    end else if (exec_go) begin
      if (bm_ctl.set) begin
        mapped[req_num] <= 1'b1;
      end else if (bm_ctl.clr) begin
        mapped[req_num] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      slot   <= res_slot;
      status <= res_status;
    end
  end

endmodule

`default_nettype wire
